/* design/spin_pkg.sv */
// Shared types, constants and helpers of the spin target detector.
package spin_pkg;

    localparam int COORD_W = 16;
    localparam int TILT_W  = 12;
    localparam int COUNT_W = 8;
    localparam int SIZE_W  = 17;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W  = 80;
    localparam int M_DATA_W  = 72;

    // Reciprocal scales: 1/1.72 and 1/1.95 in 0.16 fixed point.
    localparam logic [15:0] WIDTH_SCALE  = 16'd38103;
    localparam logic [15:0] HEIGHT_SCALE = 16'd33609;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_DIFF_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_DIFF_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_DIFF_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_DIFF_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEADY_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_THRESHOLD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_THRESHOLD   = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [COORD_W-1:0] HEIGHT_DIFF_LOW_RST  = 16'd4800;
    localparam logic [COORD_W-1:0] HEIGHT_DIFF_HIGH_RST = 16'd9600;
    localparam logic [COORD_W-1:0] WIDTH_DIFF_LOW_RST   = 16'd320;
    localparam logic [COORD_W-1:0] WIDTH_DIFF_HIGH_RST  = 16'd1280;
    localparam logic [COUNT_W-1:0] STEADY_THRESHOLD_RST = 8'd10;
    localparam logic [COUNT_W-1:0] SPIN_THRESHOLD_RST   = 8'd2;
    localparam logic [COUNT_W-1:0] LOST_THRESHOLD_RST   = 8'd22;

    typedef struct packed {
        logic [COORD_W-1:0] height_diff_low;
        logic [COORD_W-1:0] height_diff_high;
        logic [COORD_W-1:0] width_diff_low;
        logic [COORD_W-1:0] width_diff_high;
        logic [COUNT_W-1:0] steady_threshold;
        logic [COUNT_W-1:0] spin_threshold;
        logic [COUNT_W-1:0] lost_threshold;
    } cfg_t;

    typedef struct packed {
        logic                      found;
        logic [COORD_W-1:0]        center_x;
        logic [COORD_W-1:0]        center_y;
        logic signed [TILT_W-1:0]  tilt;
        logic [COORD_W-1:0]        box_width;
        logic [COORD_W-1:0]        box_height;
    } item_t;

    // Tracker state that the aim stage reads.
    typedef struct packed {
        logic [COORD_W-1:0] ref_width;
        logic [COORD_W-1:0] ref_height;
        logic [COORD_W-1:0] cur_width;
        logic [COORD_W-1:0] cur_height;
        logic [COORD_W-1:0] aim_cx;
        logic [COORD_W-1:0] aim_cy;
        logic [COUNT_W-1:0] switch_count;
    } track_state_t;

    typedef struct packed {
        logic               spinning;
        logic [COORD_W-1:0] aim_x;
        logic [COORD_W-1:0] aim_y;
        logic [SIZE_W-1:0]  aim_width;
        logic [SIZE_W-1:0]  aim_height;
    } result_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        return (c == {COUNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

endpackage

/* design/spin_track.sv */
// Tracker state and the per-frame update rules of the spin target detector.
module spin_track (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   item_en,
    input  spin_pkg::item_t        item,
    input  spin_pkg::cfg_t         cfg,
    output spin_pkg::track_state_t state
);
    import spin_pkg::*;

    logic                     ref_loaded_reg, ref_loaded_next;
    logic [COORD_W-1:0]       ref_x_reg, ref_x_next;
    logic [COORD_W-1:0]       ref_y_reg, ref_y_next;
    logic signed [TILT_W-1:0] ref_tilt_reg, ref_tilt_next;
    logic [COORD_W-1:0]       ref_width_reg, ref_width_next;
    logic [COORD_W-1:0]       ref_height_reg, ref_height_next;
    logic [COORD_W-1:0]       cur_width_reg, cur_width_next;
    logic [COORD_W-1:0]       cur_height_reg, cur_height_next;
    logic [COORD_W-1:0]       aim_cx_reg, aim_cx_next;
    logic [COORD_W-1:0]       aim_cy_reg, aim_cy_next;
    logic [COUNT_W-1:0]       switch_count_reg, switch_count_next;
    logic [COUNT_W-1:0]       steady_count_reg, steady_count_next;
    logic [COUNT_W-1:0]       lost_count_reg, lost_count_next;

    logic [COORD_W-1:0] dx, dy;
    logic [COUNT_W-1:0] lost_inc, steady_inc;
    logic [COORD_W:0]   x_sum;
    logic               opposite;

    assign dx = abs_diff(item.center_x, ref_x_reg);
    assign dy = abs_diff(item.center_y, ref_y_reg);
    assign lost_inc   = sat_inc(lost_count_reg);
    assign steady_inc = sat_inc(steady_count_reg);
    assign x_sum = {1'b0, ref_x_reg} + {1'b0, item.center_x};
    // Zero tilt counts as lying on both sides.
    assign opposite = (!item.tilt[TILT_W-1] && (ref_tilt_reg[TILT_W-1] || ref_tilt_reg == '0))
                   || ((item.tilt[TILT_W-1] || item.tilt == '0) && !ref_tilt_reg[TILT_W-1]);

    always_comb begin
        ref_loaded_next   = ref_loaded_reg;
        ref_x_next        = ref_x_reg;
        ref_y_next        = ref_y_reg;
        ref_tilt_next     = ref_tilt_reg;
        ref_width_next    = ref_width_reg;
        ref_height_next   = ref_height_reg;
        cur_width_next    = cur_width_reg;
        cur_height_next   = cur_height_reg;
        aim_cx_next       = aim_cx_reg;
        aim_cy_next       = aim_cy_reg;
        switch_count_next = switch_count_reg;
        steady_count_next = steady_count_reg;
        lost_count_next   = lost_count_reg;
        if (item_en) begin
            if (!item.found) begin
                lost_count_next = lost_inc;
                if (lost_inc >= cfg.lost_threshold) begin
                    steady_count_next = '0;
                    switch_count_next = '0;
                    aim_cx_next       = '0;
                    aim_cy_next       = '0;
                end
            end else if (!ref_loaded_reg) begin
                ref_x_next      = item.center_x;
                ref_y_next      = item.center_y;
                ref_tilt_next   = item.tilt;
                ref_width_next  = item.box_width;
                ref_height_next = item.box_height;
                ref_loaded_next = 1'b1;
            end else if (dy > cfg.height_diff_high || dx > cfg.width_diff_high) begin
                switch_count_next = '0;
                aim_cx_next       = '0;
                aim_cy_next       = '0;
            end else if (dx < cfg.width_diff_low) begin
                if (dy < cfg.height_diff_low) begin
                    steady_count_next = steady_inc;
                    if (steady_inc >= cfg.steady_threshold) begin
                        lost_count_next = '0;
                    end
                end
            end else if (dy > cfg.height_diff_low && opposite) begin
                switch_count_next = sat_inc(switch_count_reg);
                ref_loaded_next   = 1'b0;
                cur_width_next    = item.box_width;
                cur_height_next   = item.box_height;
                aim_cx_next       = x_sum[COORD_W:1];
                aim_cy_next       = item.center_y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_loaded_reg   <= 1'b0;
            ref_x_reg        <= '0;
            ref_y_reg        <= '0;
            ref_tilt_reg     <= '0;
            ref_width_reg    <= '0;
            ref_height_reg   <= '0;
            cur_width_reg    <= '0;
            cur_height_reg   <= '0;
            aim_cx_reg       <= '0;
            aim_cy_reg       <= '0;
            switch_count_reg <= '0;
            steady_count_reg <= '0;
            lost_count_reg   <= '0;
        end else begin
            ref_loaded_reg   <= ref_loaded_next;
            ref_x_reg        <= ref_x_next;
            ref_y_reg        <= ref_y_next;
            ref_tilt_reg     <= ref_tilt_next;
            ref_width_reg    <= ref_width_next;
            ref_height_reg   <= ref_height_next;
            cur_width_reg    <= cur_width_next;
            cur_height_reg   <= cur_height_next;
            aim_cx_reg       <= aim_cx_next;
            aim_cy_reg       <= aim_cy_next;
            switch_count_reg <= switch_count_next;
            steady_count_reg <= steady_count_next;
            lost_count_reg   <= lost_count_next;
        end
    end

    assign state.ref_width    = ref_width_reg;
    assign state.ref_height   = ref_height_reg;
    assign state.cur_width    = cur_width_reg;
    assign state.cur_height   = cur_height_reg;
    assign state.aim_cx       = aim_cx_reg;
    assign state.aim_cy       = aim_cy_reg;
    assign state.switch_count = switch_count_reg;

endmodule

/* design/spin_aim.sv */
// Spin decision and predicted box from the tracker state.
module spin_aim (
    input  spin_pkg::track_state_t     state,
    input  logic [spin_pkg::COUNT_W-1:0] spin_threshold,
    output spin_pkg::result_t          result
);
    import spin_pkg::*;

    logic [COORD_W:0]    width_sum, height_sum;
    logic [COORD_W+16:0] width_prod, height_prod;
    logic                spinning;

    assign width_sum   = {1'b0, state.ref_width} + {1'b0, state.cur_width};
    assign height_sum  = {1'b0, state.ref_height} + {1'b0, state.cur_height};
    assign width_prod  = width_sum * WIDTH_SCALE;
    assign height_prod = height_sum * HEIGHT_SCALE;
    assign spinning    = state.switch_count >= spin_threshold;

    always_comb begin
        result = '0;
        if (spinning) begin
            result.spinning   = 1'b1;
            result.aim_x      = state.aim_cx;
            result.aim_y      = state.aim_cy;
            result.aim_width  = width_prod[COORD_W+16:16];
            result.aim_height = height_prod[COORD_W+16:16];
        end
    end

endmodule

/* design/spin_target_detector.sv */
// Top level of the spin target detector: ports, configuration and pipeline control.
//
// The detector takes one request per video frame on the s_ channel (s_tuser is
// the found flag, s_tdata the first detection) and returns exactly one result
// request per frame on the m_ channel (m_tuser is the spinning flag, m_tdata the
// predicted box). A frame passes three registers: the input register, the
// tracker state update, and the output register where the box sizes are scaled
// by a constant multiply. A new frame can be accepted every cycle; the sustained
// rate is one frame per cycle, limited only by m_tready, since the whole pipeline
// stalls when the output register holds an untaken result. Thresholds are to be
// written through the cfg_ port only while no frame is in flight; the block does
// not enforce this. Coordinates are in 1/16 pixel. When the target is not
// declared spinning, all box fields of the result are zero.
module spin_target_detector (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [spin_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spin_pkg::CFG_W-1:0]        cfg_wdata,
    // Frame input channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata from bit 0: center_x[15:0], center_y[15:0], tilt[11:0],
    // box_width[15:0], box_height[15:0], 4 bits of zero fill.
    input  logic [spin_pkg::S_DATA_W-1:0]     s_tdata,
    // tuser: found.
    input  logic                              s_tuser,
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata from bit 0: aim_x[15:0], aim_y[15:0], aim_width[16:0],
    // aim_height[16:0], 6 bits of zero fill.
    output logic [spin_pkg::M_DATA_W-1:0]     m_tdata,
    // tuser: spinning.
    output logic                              m_tuser
);
    import spin_pkg::*;

    cfg_t         cfg_reg;
    item_t        item_reg;
    logic         item_valid_reg;
    logic         upd_valid_reg;
    result_t      result_reg;
    logic         result_valid_reg;
    track_state_t state;
    result_t      result_next;
    logic         advance;

    // The pipeline moves as a whole whenever the output register is free or
    // being emptied this cycle. An empty input register may fill at any time.
    assign advance  = !result_valid_reg || m_tready;
    assign s_tready = !item_valid_reg || advance;

    // Configuration registers; an unknown index is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.height_diff_low  <= HEIGHT_DIFF_LOW_RST;
            cfg_reg.height_diff_high <= HEIGHT_DIFF_HIGH_RST;
            cfg_reg.width_diff_low   <= WIDTH_DIFF_LOW_RST;
            cfg_reg.width_diff_high  <= WIDTH_DIFF_HIGH_RST;
            cfg_reg.steady_threshold <= STEADY_THRESHOLD_RST;
            cfg_reg.spin_threshold   <= SPIN_THRESHOLD_RST;
            cfg_reg.lost_threshold   <= LOST_THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_HEIGHT_DIFF_LOW:  cfg_reg.height_diff_low  <= cfg_wdata;
                REG_HEIGHT_DIFF_HIGH: cfg_reg.height_diff_high <= cfg_wdata;
                REG_WIDTH_DIFF_LOW:   cfg_reg.width_diff_low   <= cfg_wdata;
                REG_WIDTH_DIFF_HIGH:  cfg_reg.width_diff_high  <= cfg_wdata;
                REG_STEADY_THRESHOLD: cfg_reg.steady_threshold <= cfg_wdata[COUNT_W-1:0];
                REG_SPIN_THRESHOLD:   cfg_reg.spin_threshold   <= cfg_wdata[COUNT_W-1:0];
                REG_LOST_THRESHOLD:   cfg_reg.lost_threshold   <= cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: holds one accepted frame until the tracker consumes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.found      <= s_tuser;
            item_reg.center_x   <= s_tdata[15:0];
            item_reg.center_y   <= s_tdata[31:16];
            item_reg.tilt       <= s_tdata[43:32];
            item_reg.box_width  <= s_tdata[59:44];
            item_reg.box_height <= s_tdata[75:60];
        end
    end

    // The tracker updates its state when the held frame moves on. The flag
    // upd_valid_reg then marks that the state registers hold the outcome of
    // that frame, which the aim logic turns into the result for the output register.
    spin_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item_en (item_valid_reg && advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .state   (state)
    );

    spin_aim u_aim (
        .state          (state),
        .spin_threshold (cfg_reg.spin_threshold),
        .result         (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upd_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end else if (advance) begin
            upd_valid_reg    <= item_valid_reg;
            result_valid_reg <= upd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && upd_valid_reg) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = result_valid_reg;
    assign m_tuser  = result_reg.spinning;
    assign m_tdata  = {6'b0, result_reg.aim_height, result_reg.aim_width,
                       result_reg.aim_y, result_reg.aim_x};

endmodule
